FILE: src/hse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the hash set engine
// Opcodes of a request and the states of the control sequencer.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int KEY_PORT_BITS = 20;
    localparam int OPCODE_BITS   = 2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_UPDATE
    } state_t;

endpackage

FILE: src/hse_bucket_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_bucket_mod: key modulo bucket count
// Two registered stages: a reciprocal multiply estimates the quotient, a
// second multiply and subtract forms a remainder below twice the bucket
// count, and one compare and subtract finishes it at the output.
// ----------------------------------------------------------------------------
module hse_bucket_mod #(
    parameter int NUM_BUCKETS = 769,
    parameter int KEY_BITS    = 20,
    parameter int BIDX        = 10
) (
    input  logic                clk,
    input  logic                load,
    input  logic [KEY_BITS-1:0] key,
    output logic [BIDX-1:0]     bucket
);

    localparam longint unsigned RECIP_L = (64'd1 << KEY_BITS) / NUM_BUCKETS;
    localparam logic [KEY_BITS-1:0] RECIP   = KEY_BITS'(RECIP_L);
    localparam logic [KEY_BITS-1:0] DIVISOR = KEY_BITS'(NUM_BUCKETS);
    localparam logic [BIDX:0]       NB_EXT  = (BIDX+1)'(NUM_BUCKETS);

    logic [KEY_BITS-1:0]   key_reg;
    logic [2*KEY_BITS-1:0] prod_reg;
    logic [BIDX:0]         rem_reg;
    logic [KEY_BITS-1:0]   quot;
    logic [2*KEY_BITS-1:0] qn;
    logic [KEY_BITS-1:0]   diff;
    logic [BIDX:0]         rem_sub;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= key;
            prod_reg <= key * RECIP;
        end
    end

    // The quotient estimate is low by at most one, so the remainder stays
    // below twice the bucket count.
    always_comb
    begin
        quot = prod_reg[2*KEY_BITS-1:KEY_BITS];
        qn   = quot * DIVISOR;
        diff = key_reg - qn[KEY_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= (BIDX+1)'(diff);
    end

    always_comb
    begin
        rem_sub = rem_reg - NB_EXT;
        if (rem_reg >= NB_EXT)
            bucket = rem_sub[BIDX-1:0];
        else
            bucket = rem_reg[BIDX-1:0];
    end

endmodule

FILE: src/hse_bucket_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hse_bucket_ram: bucket store
// Simple dual-port synchronous memory, one row per bucket, registered read.
// ----------------------------------------------------------------------------
module hse_bucket_ram #(
    parameter int DEPTH = 769,
    parameter int WIDTH = 84,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/hash_set_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_set_engine_core: bounded hash set of keys
// A request (opcode, key) is taken at a clock edge where start is high and
// busy is low. Opcodes: add, remove, query; the unused code acts as a query.
// The bucket is key modulo NUM_BUCKETS; each bucket holds WAYS_PER_BUCKET
// ways of valid bit plus key, kept as one row of a synchronous memory.
// Each request runs its states in order: modulo reduction through S_REDUCE,
// one memory read in S_READ, then compare of all ways in S_UPDATE, writing
// the row back only where an add or a remove changes it. The result (found,
// bucket_full) is registered from S_UPDATE and appears with done high for
// exactly one cycle; busy drops in that same cycle, so a new request is
// taken only once the last is through, with one memory read-modify-write
// per request. found tells whether the key was present before the request;
// bucket_full marks an add dropped for lack of a free way.
// The receiver cannot stall; results must be taken when done is high.
// After reset a clearing pass writes every row invalid, one row a cycle, and
// busy stays high until it ends.
// ----------------------------------------------------------------------------
module hash_set_engine_core #(
    parameter int NUM_BUCKETS     = 769,
    parameter int WAYS_PER_BUCKET = 4,
    parameter int KEY_BITS        = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [hse_pkg::OPCODE_BITS-1:0]   opcode,
    input  logic [hse_pkg::KEY_PORT_BITS-1:0] key,
    output logic                              busy,
    output logic                              done,
    output logic                              found,
    output logic                              bucket_full
);

    localparam int BIDX  = $clog2(NUM_BUCKETS);
    localparam int WIDX  = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int ROW_W = WAYS_PER_BUCKET * (KEY_BITS + 1);

    hse_pkg::state_t state_reg, state_next;
    logic [BIDX-1:0]     clr_cnt_reg, clr_cnt_next;
    hse_pkg::op_t        op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [BIDX-1:0]     addr_reg;
    logic                done_reg, found_reg, full_reg;

    logic                accept;
    logic [KEY_BITS-1:0] key_m;
    logic [BIDX-1:0]     bucket;

    logic                ram_we;
    logic [BIDX-1:0]     ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [ROW_W-1:0]    ram_rdata;

    logic [WAYS_PER_BUCKET-1:0][KEY_BITS:0] row_q;
    logic [WAYS_PER_BUCKET-1:0][KEY_BITS:0] row_new;
    logic [WAYS_PER_BUCKET-1:0]             hit_vec;
    logic [WAYS_PER_BUCKET-1:0]             free_vec;
    logic                any_hit, any_free;
    logic [WIDX-1:0]     hit_idx, free_idx;
    logic                upd_we, full_flag;

    assign key_m  = KEY_BITS'(key);
    assign accept = start && (state_reg == hse_pkg::S_IDLE);
    assign busy   = (state_reg != hse_pkg::S_IDLE);

    hse_bucket_mod #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .KEY_BITS    (KEY_BITS),
        .BIDX        (BIDX)
    ) u_mod (
        .clk    (clk),
        .load   (accept),
        .key    (key_m),
        .bucket (bucket)
    );

    hse_bucket_ram #(
        .DEPTH (NUM_BUCKETS),
        .WIDTH (ROW_W),
        .AW    (BIDX)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (bucket),
        .rd_data (ram_rdata)
    );

    // Way compare on the row read back from memory.
    always_comb
    begin
        row_q    = ram_rdata;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS_PER_BUCKET; w++)
        begin
            hit_vec[w]  = row_q[w][KEY_BITS] && (row_q[w][KEY_BITS-1:0] == key_reg);
            free_vec[w] = !row_q[w][KEY_BITS];
        end
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
                hit_idx = WIDX'(w);
            if (free_vec[w])
                free_idx = WIDX'(w);
        end
        any_hit   = |hit_vec;
        any_free  = |free_vec;
        row_new   = row_q;
        upd_we    = 1'b0;
        full_flag = 1'b0;
        case (op_reg)
            hse_pkg::OP_ADD:
            begin
                if (!any_hit && any_free)
                begin
                    row_new[free_idx] = {1'b1, key_reg};
                    upd_we            = 1'b1;
                end
                full_flag = !any_hit && !any_free;
            end
            hse_pkg::OP_REMOVE:
            begin
                if (any_hit)
                begin
                    row_new[hit_idx] = '0;
                    upd_we           = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hse_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == hse_pkg::S_UPDATE);
            found_reg   <= (state_reg == hse_pkg::S_UPDATE) && any_hit;
            full_reg    <= (state_reg == hse_pkg::S_UPDATE) && full_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= hse_pkg::op_t'(opcode);
            key_reg <= key_m;
        end
        if (state_reg == hse_pkg::S_READ)
            addr_reg <= bucket;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = row_new;
        ram_re       = 1'b0;
        case (state_reg)
            hse_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == BIDX'(NUM_BUCKETS - 1))
                    state_next = hse_pkg::S_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            hse_pkg::S_IDLE:
            begin
                if (start)
                    state_next = hse_pkg::S_REDUCE;
            end
            hse_pkg::S_REDUCE:
            begin
                state_next = hse_pkg::S_READ;
            end
            hse_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = hse_pkg::S_UPDATE;
            end
            hse_pkg::S_UPDATE:
            begin
                ram_we     = upd_we;
                state_next = hse_pkg::S_IDLE;
            end
            default:
            begin
                state_next = hse_pkg::S_IDLE;
            end
        endcase
    end

    assign done        = done_reg;
    assign found       = found_reg;
    assign bucket_full = full_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == hse_pkg::S_UPDATE))
        else $error("done without a preceding update cycle");

    a_full_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        bucket_full |-> (done && !found))
        else $error("bucket_full outside a result or with found");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == hse_pkg::S_REDUCE))
        else $error("accepted request did not start the sequence");

    a_write_justified: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hse_pkg::S_UPDATE && ram_we) |->
            ((op_reg == hse_pkg::OP_ADD && !any_hit && any_free) ||
             (op_reg == hse_pkg::OP_REMOVE && any_hit)))
        else $error("row written back without a change");

endmodule
